FILE: rtl/core/ts_pid_start_code_scanner_top_assert.svh
// Assertion helpers for the start code scanner, clocked on clock, cleared by reset.
`ifndef TS_PID_START_CODE_SCANNER_TOP_ASSERT_SVH
`define TS_PID_START_CODE_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TSPSC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scanner assertion failed");

// Next-cycle implication.
`define TSPSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

`endif

FILE: rtl/core/tspsc_pkg.sv
package tspsc_pkg;

   localparam int unsigned PACKET_BYTES_DEF    = 188;
   localparam int unsigned SCAN_LAST_START_DEF = 180;
   localparam int unsigned PREFIX_LEN          = 3;

   localparam int unsigned POS_W       = 8;
   localparam int unsigned PID_W       = 13;
   localparam int unsigned CNT_W       = 32;
   localparam int unsigned OFFSET_W    = 40;
   localparam int unsigned CLASS_W     = 5;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [7:0]       SYNC_BYTE   = 8'h47;
   localparam logic [23:0]      START_PREFIX = 24'h000001;
   localparam logic [CNT_W-1:0] CNT_MAX     = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_PID  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_LIMIT = 8'd1;

   typedef enum logic {
      EVT_START_CODE = 1'b0,
      EVT_SYNC_ERROR = 1'b1
   } event_kind_type;

   typedef enum logic [CLASS_W-1:0] {
      CLS_PICTURE  = 5'd0,
      CLS_SLICE    = 5'd1,
      CLS_USER     = 5'd2,
      CLS_SEQHDR   = 5'd3,
      CLS_SEQERR   = 5'd4,
      CLS_EXT      = 5'd5,
      CLS_SEQEND   = 5'd6,
      CLS_GOP      = 5'd7,
      CLS_PROGEND  = 5'd8,
      CLS_PACK     = 5'd9,
      CLS_SYSTEM   = 5'd10,
      CLS_PSMAP    = 5'd11,
      CLS_AUDIO    = 5'd12,
      CLS_VIDEO    = 5'd13,
      CLS_ECM      = 5'd14,
      CLS_EMM      = 5'd15,
      CLS_PSDIR    = 5'd16,
      CLS_RESERVED = 5'd17
   } stream_class_type;

   function automatic stream_class_type classify(input logic [7:0] id);
      stream_class_type cls;
      case (id) inside
         8'h00:           cls = CLS_PICTURE;
         [8'h01:8'hAF]:   cls = CLS_SLICE;
         8'hB2:           cls = CLS_USER;
         8'hB3:           cls = CLS_SEQHDR;
         8'hB4:           cls = CLS_SEQERR;
         8'hB5:           cls = CLS_EXT;
         8'hB7:           cls = CLS_SEQEND;
         8'hB8:           cls = CLS_GOP;
         8'hB9:           cls = CLS_PROGEND;
         8'hBA:           cls = CLS_PACK;
         8'hBB:           cls = CLS_SYSTEM;
         8'hBC:           cls = CLS_PSMAP;
         [8'hC0:8'hDF]:   cls = CLS_AUDIO;
         [8'hE0:8'hEF]:   cls = CLS_VIDEO;
         8'hF0:           cls = CLS_ECM;
         8'hF1:           cls = CLS_EMM;
         8'hFF:           cls = CLS_PSDIR;
         default:         cls = CLS_RESERVED;
      endcase
      return cls;
   endfunction

endpackage

FILE: rtl/core/tspsc_if.sv
interface tspsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

interface tspsc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               event_kind;
   logic [7:0]                         stream_id;
   logic [tspsc_pkg::CLASS_W-1:0]      stream_class;
   logic [tspsc_pkg::OFFSET_W-1:0]     byte_offset;
   logic [tspsc_pkg::CNT_W-1:0]        video_pes_total;

   modport source (output valid, output event_kind, output stream_id, output stream_class,
                   output byte_offset, output video_pes_total, input ready);
   modport sink (input valid, input event_kind, input stream_id, input stream_class,
                 input byte_offset, input video_pes_total, output ready);
endinterface

interface tspsc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [tspsc_pkg::CSR_INDEX_W-1:0]  index;
   logic [tspsc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ts_pid_start_code_scanner_top.sv
// Transport stream PID filter and start code scanner. One stream byte is taken per clock
// unstalled; the result for a byte (a start code found in a packet of the selected PID, or
// a missing sync byte) sits in the output register from the next cycle, and the next byte
// is taken in the same cycle that register is emptied, so the rate is one item per cycle
// whenever the result side keeps up. All per-byte work is one pass of logic from the input
// port into the state and result registers. A sync error, or the end of a packet at which
// the matched-packet count has reached match_limit, halts the block: bytes are then still
// taken but dropped until reset. Configuration writes are taken at any time, one a cycle.
`include "ts_pid_start_code_scanner_top_assert.svh"

module ts_pid_start_code_scanner_top #(
   parameter int unsigned PACKET_BYTES    = tspsc_pkg::PACKET_BYTES_DEF,
   parameter int unsigned SCAN_LAST_START = tspsc_pkg::SCAN_LAST_START_DEF
) (
   input  logic         clock,
   input  logic         reset,
   tspsc_req_if.sink    req_chan,
   tspsc_rsp_if.source  rsp_chan,
   tspsc_csr_if.sink    csr_chan
);

   localparam int unsigned POS_W = tspsc_pkg::POS_W;

   // configuration
   logic [tspsc_pkg::PID_W-1:0]    search_pid_ff;
   logic [tspsc_pkg::CNT_W-1:0]    match_limit_ff;

   // scan state
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [23:0]                    recent_ff, recent_in;
   logic [4:0]                     pid_hi_ff, pid_hi_in;
   logic                           pid_match_ff, pid_match_in;
   logic [tspsc_pkg::CNT_W-1:0]    match_cnt_ff, match_cnt_in;
   logic [tspsc_pkg::CNT_W-1:0]    video_cnt_ff, video_cnt_in;
   logic [tspsc_pkg::OFFSET_W-1:0] stream_pos_ff, stream_pos_in;
   logic                           halted_ff, halted_in;

   // result register
   logic                           out_valid_ff, out_valid_in;
   logic                           out_kind_ff, out_kind_in;
   logic [7:0]                     out_id_ff, out_id_in;
   logic [tspsc_pkg::CLASS_W-1:0]  out_class_ff, out_class_in;
   logic [tspsc_pkg::OFFSET_W-1:0] out_offset_ff, out_offset_in;
   logic [tspsc_pkg::CNT_W-1:0]    out_total_ff, out_total_in;

   logic                           req_acc;
   logic                           out_load;
   logic                           sync_err;
   logic                           in_window;
   logic [POS_W:0]                 pos_next;
   logic [7:0]                     b;
   tspsc_pkg::stream_class_type    cls;

   assign b        = req_chan.stream_byte;
   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign cls       = tspsc_pkg::classify(b);
   assign sync_err  = (pos_ff == '0) && (b != tspsc_pkg::SYNC_BYTE);
   assign in_window = (pos_ff >= POS_W'(tspsc_pkg::PREFIX_LEN)) &&
                      (pos_ff <= POS_W'(SCAN_LAST_START + tspsc_pkg::PREFIX_LEN));
   assign pos_next  = {1'b0, pos_ff} + (POS_W+1)'(1);

   always_comb begin
      pos_in        = pos_ff;
      recent_in     = recent_ff;
      pid_hi_in     = pid_hi_ff;
      pid_match_in  = pid_match_ff;
      match_cnt_in  = match_cnt_ff;
      video_cnt_in  = video_cnt_ff;
      stream_pos_in = stream_pos_ff;
      halted_in     = halted_ff;
      out_load      = 1'b0;
      out_kind_in   = tspsc_pkg::EVT_START_CODE;
      out_id_in     = b;
      out_class_in  = cls;
      out_offset_in = stream_pos_ff - tspsc_pkg::OFFSET_W'(tspsc_pkg::PREFIX_LEN);
      out_total_in  = video_cnt_ff;

      if (req_acc && !halted_ff) begin
         if (sync_err) begin
            out_load      = 1'b1;
            out_kind_in   = tspsc_pkg::EVT_SYNC_ERROR;
            out_id_in     = '0;
            out_class_in  = tspsc_pkg::CLS_PICTURE;
            out_offset_in = stream_pos_ff;
            halted_in     = 1'b1;
         end else begin
            if (pos_ff == POS_W'(1)) begin
               pid_hi_in = b[4:0];
            end else if (pos_ff == POS_W'(2)) begin
               pid_match_in = ({pid_hi_ff, b} == search_pid_ff);
               if (pid_match_in && match_cnt_ff != tspsc_pkg::CNT_MAX)
                  match_cnt_in = match_cnt_ff + tspsc_pkg::CNT_W'(1);
            end else if (in_window && pid_match_ff && recent_ff == tspsc_pkg::START_PREFIX) begin
               if (cls == tspsc_pkg::CLS_VIDEO && video_cnt_ff != tspsc_pkg::CNT_MAX)
                  video_cnt_in = video_cnt_ff + tspsc_pkg::CNT_W'(1);
               out_load     = 1'b1;
               out_total_in = video_cnt_in;
            end

            recent_in     = {recent_ff[15:0], b};
            stream_pos_in = stream_pos_ff + tspsc_pkg::OFFSET_W'(1);

            // packet end: the limit is checked only here
            if (pos_next >= (POS_W+1)'(PACKET_BYTES)) begin
               pos_in       = '0;
               pid_match_in = 1'b0;
               if (match_cnt_in >= match_limit_ff)
                  halted_in = 1'b1;
            end else begin
               pos_in = pos_next[POS_W-1:0];
            end
         end
      end
   end

   always_comb begin
      if (out_load)
         out_valid_in = 1'b1;
      else if (rsp_chan.ready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_pid_ff  <= '0;
         match_limit_ff <= tspsc_pkg::CNT_MAX;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            tspsc_pkg::CSR_SEARCH_PID:  search_pid_ff  <= csr_chan.data[tspsc_pkg::PID_W-1:0];
            tspsc_pkg::CSR_MATCH_LIMIT: match_limit_ff <= csr_chan.data[tspsc_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         recent_ff     <= '0;
         pid_hi_ff     <= '0;
         pid_match_ff  <= 1'b0;
         match_cnt_ff  <= '0;
         video_cnt_ff  <= '0;
         stream_pos_ff <= '0;
         halted_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         recent_ff     <= recent_in;
         pid_hi_ff     <= pid_hi_in;
         pid_match_ff  <= pid_match_in;
         match_cnt_ff  <= match_cnt_in;
         video_cnt_ff  <= video_cnt_in;
         stream_pos_ff <= stream_pos_in;
         halted_ff     <= halted_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff   <= out_kind_in;
         out_id_ff     <= out_id_in;
         out_class_ff  <= out_class_in;
         out_offset_ff <= out_offset_in;
         out_total_ff  <= out_total_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.event_kind      = out_kind_ff;
   assign rsp_chan.stream_id       = out_id_ff;
   assign rsp_chan.stream_class    = out_class_ff;
   assign rsp_chan.byte_offset     = out_offset_ff;
   assign rsp_chan.video_pes_total = out_total_ff;

   // halt is sticky until reset
   `TSPSC_ASSERT_NEXT(a_halt_sticky, halted_ff, halted_ff)
   // a halted block leaves the stream position and video count alone
   `TSPSC_ASSERT_NEXT(a_halt_frozen, halted_ff, $stable(stream_pos_ff) && $stable(video_cnt_ff))
   // a sync error halts and posts an item
   `TSPSC_ASSERT_NEXT(a_sync_halts, req_acc && !halted_ff && sync_err, halted_ff && out_valid_ff)
   // packet position never runs past the packet
   `TSPSC_ASSERT_NOW(a_pos_range, 1'b1, pos_ff < POS_W'(PACKET_BYTES))

endmodule
